FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every rising clock edge out of reset
`define WEPI_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication with the consequent checked in the next cycle
`define WEPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wepi_pkg.sv
`default_nettype none

package wepi_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic signed [15:0] GROUP_A_RESET     = 16'sd1;
    localparam logic signed [15:0] GROUP_B_RESET     = 16'sd2;
    localparam logic [31:0]        WINDOW_SIZE_RESET = 32'd150;

    localparam logic signed [31:0] INTERVAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INTERVAL_MIN = 32'sh8000_0001;

    typedef enum logic [1:0] {
        REG_GROUP_A     = 2'd0,
        REG_GROUP_B     = 2'd1,
        REG_WINDOW_SIZE = 2'd2
    } reg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN_RD  = 6'b000010,
        ST_SCAN_CHK = 6'b000100,
        ST_EMIT_RD  = 6'b001000,
        ST_EMIT_NEG = 6'b010000,
        ST_EMIT_POS = 6'b100000
    } state_t;

    typedef struct packed {
        logic [31:0]        event_time;
        logic signed [15:0] event_group;
        logic               first_of_record;
    } event_t;

    typedef struct packed {
        logic signed [31:0] interval;
        logic               last_of_run;
        logic               window_overflow;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/windowed_event_pair_intervals.sv
`default_nettype none

// Pairs each event of group A or B with the stored kept events, newest first, up to the
// first one that lies more than half a window before it, and sends two intervals per pair
// (stored minus new, then its negation, both clipped to +/-2147483647). Events of other
// groups produce no beat and are not stored; first_of_record clears the window. One
// subtractor, fed by a single registered read port of the window ring, serves both a
// counting pass and an emitting pass, so the block takes one event at a time and keeps
// event_stall high until it is back in idle, also while the result side stalls.
// window_overflow is set on every beat of an event when the ring was full and no stored
// entry fell outside the window.
module windowed_event_pair_intervals #(
    parameter int DEPTH = wepi_pkg::DEPTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [1:0]            cfg_index,
    input  wire [31:0]           cfg_data,
    input  wire                  event_valid,
    output logic                 event_stall,
    input  wire wepi_pkg::event_t event_beat,
    output logic                 result_valid,
    input  wire                  result_stall,
    output wepi_pkg::result_t    result_beat
);

`include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0)
            r = AW'(DEPTH - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    logic signed [15:0] group_a_reg;
    logic signed [15:0] group_b_reg;
    logic [31:0]        window_size_reg;

    wepi_pkg::state_t   state_reg, state_next;
    logic [31:0]        t_reg, t_next;
    logic [AW-1:0]      wslot_reg, wslot_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      rptr_reg, rptr_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      npairs_reg, npairs_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] sat_reg, sat_next;
    logic               out_valid_reg, out_valid_next;
    wepi_pkg::result_t  out_data_reg, out_data_next;

    logic [31:0]        mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic               mem_we;

    logic signed [33:0] diff;
    logic signed [33:0] neg_half;
    logic               in_window;
    logic signed [31:0] diff_sat;
    logic               out_free;
    logic               accept;
    logic               kept;
    logic [AW-1:0]      wslot_eff;
    logic [CW-1:0]      count_eff;
    logic               scan_last;
    logic               emit_last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_a_reg     <= wepi_pkg::GROUP_A_RESET;
            group_b_reg     <= wepi_pkg::GROUP_B_RESET;
            window_size_reg <= wepi_pkg::WINDOW_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wepi_pkg::REG_GROUP_A:     group_a_reg     <= cfg_data[15:0];
                wepi_pkg::REG_GROUP_B:     group_b_reg     <= cfg_data[15:0];
                wepi_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // window ring, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wslot_reg] <= t_reg;
        end
        rd_data_reg <= mem[rptr_reg];
    end

    // the shared subtractor: stored time minus new time
    assign diff      = $signed({2'b00, rd_data_reg}) - $signed({2'b00, t_reg});
    assign neg_half  = -$signed({3'b000, window_size_reg[31:1]});
    assign in_window = (diff >= neg_half);

    always_comb
    begin
        if (diff > 34'sd2147483647)
            diff_sat = wepi_pkg::INTERVAL_MAX;
        else if (diff < -34'sd2147483647)
            diff_sat = wepi_pkg::INTERVAL_MIN;
        else
            diff_sat = diff[31:0];
    end

    assign event_stall  = (state_reg != wepi_pkg::ST_IDLE);
    assign accept       = event_valid && !event_stall;
    assign kept         = (event_beat.event_group == group_a_reg)
                       || (event_beat.event_group == group_b_reg);
    assign wslot_eff    = event_beat.first_of_record ? '0 : wslot_reg;
    assign count_eff    = event_beat.first_of_record ? '0 : count_reg;
    assign out_free     = !out_valid_reg || !result_stall;
    assign scan_last    = (CW'(k_reg + 1'b1) == count_reg);
    assign emit_last    = (CW'(k_reg + 1'b1) == npairs_reg);
    assign result_valid = out_valid_reg;
    assign result_beat  = out_data_reg;

    // push of the new time happens on the cycle the sequencer returns to idle
    logic push;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        wslot_next     = wslot_reg;
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        k_next         = k_reg;
        npairs_next    = npairs_reg;
        ovf_next       = ovf_reg;
        sat_next       = sat_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && result_stall;
        push           = 1'b0;

        unique case (state_reg)
            wepi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    t_next     = event_beat.event_time;
                    wslot_next = wslot_eff;
                    count_next = count_eff;
                    if (kept)
                    begin
                        rptr_next   = ptr_dec(wslot_eff);
                        k_next      = '0;
                        npairs_next = '0;
                        ovf_next    = 1'b0;
                        if (count_eff == '0)
                            state_next = wepi_pkg::ST_EMIT_POS;
                        else
                            state_next = wepi_pkg::ST_SCAN_RD;
                    end
                end
            end
            wepi_pkg::ST_SCAN_RD:
            begin
                state_next = wepi_pkg::ST_SCAN_CHK;
            end
            wepi_pkg::ST_SCAN_CHK:
            begin
                if (in_window && !scan_last)
                begin
                    npairs_next = CW'(npairs_reg + 1'b1);
                    k_next      = CW'(k_reg + 1'b1);
                    rptr_next   = ptr_dec(rptr_reg);
                    state_next  = wepi_pkg::ST_SCAN_RD;
                end
                else
                begin
                    if (in_window)
                        npairs_next = CW'(npairs_reg + 1'b1);
                    ovf_next  = in_window && (count_reg == CW'(DEPTH));
                    k_next    = '0;
                    rptr_next = ptr_dec(wslot_reg);
                    // no pair in the window: go straight to the push
                    if (npairs_next == '0)
                        state_next = wepi_pkg::ST_EMIT_POS;
                    else
                        state_next = wepi_pkg::ST_EMIT_RD;
                end
            end
            wepi_pkg::ST_EMIT_RD:
            begin
                state_next = wepi_pkg::ST_EMIT_NEG;
            end
            wepi_pkg::ST_EMIT_NEG:
            begin
                if (out_free)
                begin
                    sat_next                      = diff_sat;
                    out_valid_next                = 1'b1;
                    out_data_next.interval        = diff_sat;
                    out_data_next.last_of_run     = 1'b0;
                    out_data_next.window_overflow = ovf_reg;
                    state_next                    = wepi_pkg::ST_EMIT_POS;
                end
            end
            wepi_pkg::ST_EMIT_POS:
            begin
                // zero pairs arrive here too, then only the push is done
                if (npairs_reg == '0)
                begin
                    push       = 1'b1;
                    state_next = wepi_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.interval        = -sat_reg;
                    out_data_next.last_of_run     = emit_last;
                    out_data_next.window_overflow = ovf_reg;
                    if (emit_last)
                    begin
                        push       = 1'b1;
                        state_next = wepi_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = CW'(k_reg + 1'b1);
                        rptr_next  = ptr_dec(rptr_reg);
                        state_next = wepi_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = wepi_pkg::ST_IDLE;
            end
        endcase

        if (push)
        begin
            wslot_next = ptr_inc(wslot_reg);
            if (count_reg != CW'(DEPTH))
                count_next = CW'(count_reg + 1'b1);
        end
    end

    assign mem_we = push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wepi_pkg::ST_IDLE;
            wslot_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wslot_reg     <= wslot_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        rptr_reg     <= rptr_next;
        k_reg        <= k_next;
        npairs_reg   <= npairs_next;
        ovf_reg      <= ovf_next;
        sat_reg      <= sat_next;
        out_data_reg <= out_data_next;
    end

    `WEPI_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH),
        "stored count above ring depth")
    `WEPI_ASSERT_ALWAYS(a_pairs_bound, clk, rst_n,
        (state_reg != wepi_pkg::ST_EMIT_NEG) || (npairs_reg <= count_reg),
        "more pairs than stored entries")
    `WEPI_ASSERT_NEXT(a_push_count, clk, rst_n, push, count_reg != '0,
        "push left the ring empty")
    `WEPI_ASSERT_NEXT(a_last_idle, clk, rst_n,
        (state_reg == wepi_pkg::ST_EMIT_POS) && out_free && (npairs_reg != '0) && emit_last,
        result_valid && result_beat.last_of_run && (state_reg == wepi_pkg::ST_IDLE),
        "final beat not flagged or sequencer not back to idle")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH     = wepi_pkg::DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_EVENTS   = 15;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_pattern_t;

    // tracks the kept-event ring and predicts the interval beats of each event
    class interval_scoreboard;
        logic [31:0]        kept_times [RING_DEPTH];
        int unsigned        next_slot;
        int unsigned        kept_count;
        logic signed [15:0] grp_a;
        logic signed [15:0] grp_b;
        logic [31:0]        win_size;
        wepi_pkg::result_t  expected_intervals [$];
        int                 events_in;
        int                 kept_in;
        int                 beats_checked;
        int                 overflow_beats;
        int                 clipped_beats;
        int                 failures;

        function new();
            next_slot      = 0;
            kept_count     = 0;
            grp_a          = wepi_pkg::GROUP_A_RESET;
            grp_b          = wepi_pkg::GROUP_B_RESET;
            win_size       = wepi_pkg::WINDOW_SIZE_RESET;
            events_in      = 0;
            kept_in        = 0;
            beats_checked  = 0;
            overflow_beats = 0;
            clipped_beats  = 0;
            failures       = 0;
        endfunction

        function void set_reg(wepi_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                wepi_pkg::REG_GROUP_A:     grp_a = value[15:0];
                wepi_pkg::REG_GROUP_B:     grp_b = value[15:0];
                wepi_pkg::REG_WINDOW_SIZE: win_size = value;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clip_interval(longint value);
            if (value > longint'(wepi_pkg::INTERVAL_MAX))
                return wepi_pkg::INTERVAL_MAX;
            if (value < longint'(wepi_pkg::INTERVAL_MIN))
                return wepi_pkg::INTERVAL_MIN;
            return value[31:0];
        endfunction

        function void take_event(wepi_pkg::event_t ev);
            wepi_pkg::result_t run [$];
            wepi_pkg::result_t beat;
            longint      half;
            longint      gap;
            int unsigned slot;
            bit          in_reach;
            bit          ovf;
            int          k;
            events_in++;
            half = longint'({32'h0, win_size >> 1});
            if (ev.first_of_record)
            begin
                next_slot  = 0;
                kept_count = 0;
            end
            if (ev.event_group != grp_a && ev.event_group != grp_b)
                return;
            kept_in++;
            in_reach = 1'b1;
            beat     = '0;
            // newest first, stop at the first entry older than half a window
            for (k = 0; k < kept_count && in_reach; k++)
            begin
                slot = (next_slot + RING_DEPTH - 1 - k) % RING_DEPTH;
                gap  = longint'({32'h0, kept_times[slot]}) - longint'({32'h0, ev.event_time});
                if (gap < -half)
                    in_reach = 1'b0;
                else
                begin
                    beat.interval = clip_interval(gap);
                    run.push_back(beat);
                    beat.interval = clip_interval(-gap);
                    run.push_back(beat);
                end
            end
            ovf = (kept_count >= RING_DEPTH) && in_reach;
            foreach (run[i])
            begin
                beat                 = run[i];
                beat.window_overflow = ovf;
                beat.last_of_run     = (i == run.size() - 1);
                expected_intervals.push_back(beat);
            end
            kept_times[next_slot] = ev.event_time;
            next_slot             = (next_slot + 1) % RING_DEPTH;
            if (kept_count < RING_DEPTH)
                kept_count++;
        endfunction

        function void check_interval(wepi_pkg::result_t got);
            wepi_pkg::result_t want;
            if (expected_intervals.size() == 0)
            begin
                $error("result beat with nothing pending: interval %0d last %0b overflow %0b",
                       got.interval, got.last_of_run, got.window_overflow);
                failures++;
                return;
            end
            want = expected_intervals.pop_front();
            beats_checked++;
            if (want.window_overflow)
                overflow_beats++;
            if (want.interval == wepi_pkg::INTERVAL_MAX || want.interval == wepi_pkg::INTERVAL_MIN)
                clipped_beats++;
            if (got.interval !== want.interval)
            begin
                $error("interval: expected %0d, got %0d", want.interval, got.interval);
                failures++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
                failures++;
            end
            if (got.window_overflow !== want.window_overflow)
            begin
                $error("window_overflow: expected %0b, got %0b",
                       want.window_overflow, got.window_overflow);
                failures++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [1:0]        cfg_index    = '0;
    logic [31:0]       cfg_data     = '0;
    logic              event_valid  = 1'b0;
    logic              event_stall;
    wepi_pkg::event_t  event_beat   = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    wepi_pkg::result_t result_beat;

    interval_scoreboard board;

    int             burst_left  = 0;
    int             idle_cycles = 0;
    int             stall_run   = 0;
    stall_pattern_t stall_mode  = STALL_NONE;
    logic [31:0]    record_time = '0;

    windowed_event_pair_intervals dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_beat   (event_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure in randomly chosen patterns
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_pattern_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(16, 96);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:     result_stall = 1'b0;
            STALL_LIGHT:    result_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall = ($urandom_range(0, 1) == 1);
            default:        result_stall = ((stall_run % 7) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                board.check_interval(result_beat);
            if ((result_valid && !result_stall) || (event_valid && !event_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no beat moved for %0d cycles, %0d results still pending",
                       idle_cycles, board.expected_intervals.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic wepi_pkg::event_t mk_event(logic [31:0] t, logic signed [15:0] g,
                                                  logic f);
        wepi_pkg::event_t ev;
        ev.event_time      = t;
        ev.event_group     = g;
        ev.first_of_record = f;
        return ev;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_event(input wepi_pkg::event_t ev);
        int gap_len;
        event_beat  = ev;
        event_valid = 1'b1;
        @(posedge clk);
        while (event_stall)
            @(posedge clk);
        board.take_event(ev);
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap_len = $urandom_range(0, 6);
            if (gap_len > 0)
            begin
                event_valid = 1'b0;
                repeat (gap_len) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        else
            burst_left--;
    endtask

    // hold the sender until every pending beat is back and the block has gone quiet
    task automatic drain_results();
        event_valid = 1'b0;
        while (board.expected_intervals.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic signed [15:0] a, input logic signed [15:0] b,
                                 input logic [31:0] ws);
        logic [31:0]          vals [3];
        wepi_pkg::reg_index_t idx;
        // upper bits of the group writes carry junk that must be ignored
        vals[0] = {16'($urandom), a};
        vals[1] = {16'($urandom), b};
        vals[2] = ws;
        for (int i = 0; i < 3; i++)
        begin
            idx       = wepi_pkg::reg_index_t'(i);
            cfg_index = idx;
            cfg_data  = vals[i];
            cfg_wr_en = 1'b1;
            @(negedge clk);
            board.set_reg(idx, vals[i]);
        end
        cfg_wr_en = 1'b0;
    endtask

    task automatic run_random(input int kept_target);
        wepi_pkg::event_t ev;
        int          kept;
        int          roll;
        logic [31:0] half;
        logic [31:0] step;
        logic [32:0] sum;
        kept = 0;
        half = board.win_size >> 1;
        while (kept < kept_target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                ev.event_time      = $urandom;
                ev.event_group     = 16'($urandom);
                ev.first_of_record = ($urandom_range(0, 4) == 0);
            end
            else
            begin
                ev.event_group     = $urandom_range(0, 1) ? board.grp_a : board.grp_b;
                ev.first_of_record = 1'b0;
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: step = $urandom_range(0, 3);
                    4, 5:       step = $urandom_range(0, half >> 2);
                    6:          step = half + $urandom_range(1, 3);
                    default:    step = '0;
                endcase
                sum = {1'b0, record_time} + step;
                if (kept == 0 || roll < 17 || sum[32])
                begin
                    ev.first_of_record = 1'b1;
                    record_time        = $urandom;
                end
                else if (roll < 22)
                    record_time = record_time - $urandom_range(1, 300);
                else
                    record_time = sum[31:0];
                ev.event_time = record_time;
                kept++;
            end
            send_event(ev);
            if (roll >= 12 && kept == kept_target / 2)
                drain_results();
        end
    endtask

    initial
    begin
        board = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: groups 1 and 2, half window 75
        send_event(mk_event(32'd100, 16'sd1, 1'b1));        // nothing stored yet
        send_event(mk_event(32'd150, 16'sd2, 1'b0));
        send_event(mk_event(32'd160, 16'sd7, 1'b1));        // dropped group still clears
        send_event(mk_event(32'd170, 16'sd1, 1'b0));
        send_event(mk_event(32'd245, 16'sd2, 1'b0));        // exactly half a window back
        send_event(mk_event(32'd321, 16'sd1, 1'b0));        // one past the edge
        send_event(mk_event(32'd16, 16'sd2, 1'b0));         // time goes backwards
        send_event(mk_event(32'hFFFF_FFFF, 16'sd1, 1'b1));
        send_event(mk_event(32'd0, 16'sd2, 1'b0));          // interval clips both ways
        drain_results();

        // widest window, extreme ids: fill the ring until it overflows
        apply_setting(-16'sd32768, 16'sd32767, 32'hFFFF_FFFF);
        for (int i = 0; i <= RING_DEPTH; i++)
            send_event(mk_event(32'd1000 + i, (i % 2) ? 16'sd32767 : -16'sd32768, i == 0));
        drain_results();

        apply_setting(16'($urandom), 16'($urandom), $urandom_range(2, 400));
        run_random(PHASE_EVENTS);
        drain_results();
        apply_setting(16'sd0, -16'sd1, 32'd0);
        run_random(PHASE_EVENTS);
        drain_results();
        apply_setting(16'($urandom), 16'($urandom), 32'd1);
        run_random(PHASE_EVENTS);
        drain_results();
        apply_setting(16'sd32767, -16'sd32768, 32'hFFFF_FFFF);
        run_random(PHASE_EVENTS);
        drain_results();
        begin
            logic signed [15:0] same_grp;
            same_grp = 16'($urandom);
            apply_setting(same_grp, same_grp, $urandom);
        end
        run_random(PHASE_EVENTS);
        drain_results();
        apply_setting(16'($urandom), 16'($urandom), $urandom_range(20, 5000));
        run_random(PHASE_EVENTS);
        drain_results();

        $display("tb_top: %0d events sent, %0d kept, %0d interval beats checked",
                 board.events_in, board.kept_in, board.beats_checked);
        $display("tb_top: %0d beats flagged overflow, %0d clipped, over 8 register settings",
                 board.overflow_beats, board.clipped_beats);
        if (board.failures == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
